/* rtl/gmig_pkg.sv */
// gmig_pkg: shared types and constants for the grid mesh index generator
// no dependencies; imported by every module of the block

package gmig_pkg;

   // fixed field widths
   localparam int IDX_W     = 20;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 1;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_idx_type;

   // list selection codes
   localparam logic LIST_EDGE = 1'b0;
   localparam logic LIST_TRI  = 1'b1;

   // edge list phases
   localparam logic PHASE_COLUMN = 1'b0;
   localparam logic PHASE_ROW    = 1'b1;

   // triangle corner slots within one cell
   localparam logic [2:0] SLOT_BASE_A   = 3'd0;
   localparam logic [2:0] SLOT_NEXT_ROW = 3'd1;
   localparam logic [2:0] SLOT_DIAG_A   = 3'd2;
   localparam logic [2:0] SLOT_DIAG_B   = 3'd3;
   localparam logic [2:0] SLOT_NEXT_COL = 3'd4;
   localparam logic [2:0] SLOT_BASE_B   = 3'd5;

   // traversal control state, apart from the counters
   typedef struct packed {
      logic       active_list;
      logic       edge_phase;
      logic       row_pass_step;
      logic [2:0] corner_slot;
   } trav_ctl_type;

endpackage

/* rtl/grid_mesh_index_generator_unit.sv */
// grid_mesh_index_generator_unit: top level, beat registers and traversal state
// depends on gmig_pkg, gmig_csr, gmig_step
//
// Usage:
//   req channel: one beat (kind, restart) asks for the next index of the edge
//   line strip (kind 0) or the triangle list (kind 1); restart, or a kind that
//   differs from the previous beat's, starts that list from its first index.
//   rsp channel: one beat per request, rsp_vertex_index plus rsp_last on the
//   final index of the list, after which the list wraps to its start.
//   csr port: grid_rows (index 0) and grid_cols (index 1), clamped to 2..MAX_DIM;
//   a write returns the traversal to the first index. Write only when idle.
// Timing:
//   a request beat lands in an input register, the index is computed by one
//   multiply and add into the result register, which drives rsp_valid and
//   holds the result beat until it is taken.
//   One beat per cycle is sustained while the receiver does not stall, limited
//   by the single multiply-add step between the two registers.
//   If the receiver stalls, the result register holds and an empty input
//   register still takes one more beat before req_stall rises.
// Reset: synchronous, clears the valid flags of both beat registers, the
//   traversal state and sets both dimensions to 2.

module grid_mesh_index_generator_unit #(
   parameter int MAX_DIM = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gmig_pkg::IDX_W-1:0]      rsp_vertex_index,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [gmig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmig_pkg::CSR_W-1:0]      csr_wdata
);
   import gmig_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);

   logic [DIM_W-1:0] grid_rows;
   logic [DIM_W-1:0] grid_cols;

   logic             in_valid_ff, in_valid_in;
   logic             in_kind_ff, in_restart_ff;
   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_index_ff;
   logic             out_last_ff;

   trav_ctl_type     ctl_ff, ctl_in, ctl_nxt;
   logic [CNT_W-1:0] outer_ff, outer_in, outer_nxt;
   logic [CNT_W-1:0] inner_ff, inner_in, inner_nxt;
   logic [IDX_W-1:0] step_index;
   logic             step_last;

   logic             req_fire;
   logic             advance;
   logic             step_fire;

   gmig_csr #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .grid_rows (grid_rows),
      .grid_cols (grid_cols)
   );

   gmig_step #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W),
      .CNT_W   (CNT_W)
   ) u_step (
      .kind         (in_kind_ff),
      .restart      (in_restart_ff),
      .grid_rows    (grid_rows),
      .grid_cols    (grid_cols),
      .ctl_cur      (ctl_ff),
      .outer_cur    (outer_ff),
      .inner_cur    (inner_ff),
      .ctl_nxt      (ctl_nxt),
      .outer_nxt    (outer_nxt),
      .inner_nxt    (inner_nxt),
      .vertex_index (step_index),
      .last         (step_last)
   );

   // handshake: result register frees when empty or taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // traversal state: csr write rewinds the active list
   always_comb begin
      ctl_in   = ctl_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (csr_wr_en) begin
         ctl_in             = '0;
         ctl_in.active_list = ctl_ff.active_list;
         outer_in           = '0;
         inner_in           = '0;
      end else if (step_fire) begin
         ctl_in   = ctl_nxt;
         outer_in = outer_nxt;
         inner_in = inner_nxt;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= '0;
         outer_ff     <= '0;
         inner_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctl_ff       <= ctl_in;
         outer_ff     <= outer_in;
         inner_ff     <= inner_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff    <= req_kind;
         in_restart_ff <= req_restart;
      end
      if (step_fire) begin
         out_index_ff <= step_index;
         out_last_ff  <= step_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_vertex_index = out_index_ff;
   assign rsp_last         = out_last_ff;

endmodule

/* rtl/gmig_csr.sv */
// gmig_csr: grid dimension registers, clamped to 2..MAX_DIM on write
// depends on gmig_pkg

module gmig_csr #(
   parameter int MAX_DIM = 1024,
   parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [gmig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmig_pkg::CSR_W-1:0]      csr_wdata,
   output logic [DIM_W-1:0]                grid_rows,
   output logic [DIM_W-1:0]                grid_cols
);
   import gmig_pkg::*;

   localparam int CMP_W = (CSR_W > DIM_W) ? CSR_W : DIM_W;

   logic [CMP_W-1:0] wdata_ext;
   logic [DIM_W-1:0] dim_clamped;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;

   // clamp the written value into the legal dimension range
   always_comb begin
      wdata_ext = CMP_W'(csr_wdata);
      if (wdata_ext < CMP_W'(2)) begin
         dim_clamped = DIM_W'(2);
      end else if (wdata_ext > CMP_W'(MAX_DIM)) begin
         dim_clamped = DIM_W'(MAX_DIM);
      end else begin
         dim_clamped = DIM_W'(wdata_ext);
      end
   end

   // register decode
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_GRID_ROWS: rows_in = dim_clamped;
            CSR_GRID_COLS: cols_in = dim_clamped;
            default: begin
               rows_in = rows_ff;
               cols_in = cols_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(2);
         cols_ff <= DIM_W'(2);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign grid_rows = rows_ff;
   assign grid_cols = cols_ff;

endmodule

/* rtl/gmig_step.sv */
// gmig_step: combinational next-index logic for one beat, one shared multiplier
// depends on gmig_pkg

module gmig_step #(
   parameter int MAX_DIM = 1024,
   parameter int DIM_W   = $clog2(MAX_DIM + 1),
   parameter int CNT_W   = $clog2(MAX_DIM)
) (
   input  logic                          kind,
   input  logic                          restart,
   input  logic [DIM_W-1:0]              grid_rows,
   input  logic [DIM_W-1:0]              grid_cols,
   input  gmig_pkg::trav_ctl_type        ctl_cur,
   input  logic [CNT_W-1:0]              outer_cur,
   input  logic [CNT_W-1:0]              inner_cur,
   output gmig_pkg::trav_ctl_type        ctl_nxt,
   output logic [CNT_W-1:0]              outer_nxt,
   output logic [CNT_W-1:0]              inner_nxt,
   output logic [gmig_pkg::IDX_W-1:0]    vertex_index,
   output logic                          last
);
   import gmig_pkg::*;

   localparam int PROD_W = CNT_W + DIM_W;
   localparam int SUM_W  = (PROD_W + 1 > IDX_W) ? PROD_W + 1 : IDX_W;

   trav_ctl_type     ctl_s;
   logic [CNT_W-1:0] outer_s;
   logic [CNT_W-1:0] inner_s;
   logic [DIM_W-1:0] outer_inc;
   logic [DIM_W-1:0] inner_inc;
   logic [DIM_W-1:0] row_sel;
   logic [DIM_W-1:0] col_sel;
   logic [CNT_W-1:0] mul_col;
   logic [SUM_W-1:0] add_off;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0] sum;

   // a restart or a list change begins the chosen list afresh
   always_comb begin
      if (restart || (kind != ctl_cur.active_list)) begin
         ctl_s             = '0;
         ctl_s.active_list = kind;
         outer_s           = '0;
         inner_s           = '0;
      end else begin
         ctl_s   = ctl_cur;
         outer_s = outer_cur;
         inner_s = inner_cur;
      end
      outer_inc = DIM_W'(outer_s) + DIM_W'(1);
      inner_inc = DIM_W'(inner_s) + DIM_W'(1);
   end

   // operand selection for column * rows + offset
   always_comb begin
      row_sel = '0;
      col_sel = '0;
      mul_col = '0;
      add_off = '0;
      if (ctl_s.active_list == LIST_EDGE) begin
         if (ctl_s.edge_phase == PHASE_COLUMN) begin
            // down even columns, up odd columns
            mul_col = outer_s;
            row_sel = outer_s[0] ? (grid_rows - DIM_W'(inner_s) - DIM_W'(1))
                                 : DIM_W'(inner_s);
            add_off = SUM_W'(row_sel);
         end else begin
            // back across the rows, alternating direction
            row_sel = ctl_s.row_pass_step ? (grid_rows - DIM_W'(outer_s) - DIM_W'(1))
                                          : DIM_W'(outer_s);
            col_sel = outer_s[0] ? DIM_W'(inner_s)
                                 : (grid_cols - DIM_W'(inner_s) - DIM_W'(1));
            mul_col = CNT_W'(col_sel);
            add_off = SUM_W'(row_sel);
         end
      end else begin
         // cell base plus corner offset
         mul_col = inner_s;
         case (ctl_s.corner_slot)
            SLOT_NEXT_ROW: add_off = SUM_W'(outer_s) + SUM_W'(1);
            SLOT_DIAG_A,
            SLOT_DIAG_B:   add_off = SUM_W'(outer_s) + SUM_W'(grid_rows) + SUM_W'(1);
            SLOT_NEXT_COL: add_off = SUM_W'(outer_s) + SUM_W'(grid_rows);
            default:       add_off = SUM_W'(outer_s);
         endcase
      end
   end

   assign prod         = PROD_W'(mul_col) * PROD_W'(grid_rows);
   assign sum          = SUM_W'(prod) + add_off;
   assign vertex_index = sum[IDX_W-1:0];

   // counter advance
   always_comb begin
      ctl_nxt   = ctl_s;
      outer_nxt = outer_s;
      inner_nxt = inner_s;
      last      = 1'b0;
      if (ctl_s.active_list == LIST_EDGE) begin
         if (ctl_s.edge_phase == PHASE_COLUMN) begin
            if (inner_inc >= grid_rows) begin
               inner_nxt = '0;
               if (outer_inc >= grid_cols) begin
                  outer_nxt             = '0;
                  ctl_nxt.edge_phase    = PHASE_ROW;
                  ctl_nxt.row_pass_step = grid_cols[0];
               end else begin
                  outer_nxt = CNT_W'(outer_inc);
               end
            end else begin
               inner_nxt = CNT_W'(inner_inc);
            end
         end else begin
            if (inner_inc >= grid_cols) begin
               inner_nxt = '0;
               if (outer_inc >= grid_rows) begin
                  last                  = 1'b1;
                  outer_nxt             = '0;
                  ctl_nxt.edge_phase    = PHASE_COLUMN;
                  ctl_nxt.row_pass_step = 1'b0;
                  ctl_nxt.corner_slot   = SLOT_BASE_A;
               end else begin
                  outer_nxt = CNT_W'(outer_inc);
               end
            end else begin
               inner_nxt = CNT_W'(inner_inc);
            end
         end
      end else begin
         if (ctl_s.corner_slot >= SLOT_BASE_B) begin
            ctl_nxt.corner_slot = SLOT_BASE_A;
            if (inner_inc >= grid_cols - DIM_W'(1)) begin
               inner_nxt = '0;
               if (outer_inc >= grid_rows - DIM_W'(1)) begin
                  last                  = 1'b1;
                  outer_nxt             = '0;
                  ctl_nxt.edge_phase    = PHASE_COLUMN;
                  ctl_nxt.row_pass_step = 1'b0;
               end else begin
                  outer_nxt = CNT_W'(outer_inc);
               end
            end else begin
               inner_nxt = CNT_W'(inner_inc);
            end
         end else begin
            ctl_nxt.corner_slot = ctl_s.corner_slot + 3'd1;
         end
      end
   end

endmodule

/* rtl/gmig_checker.sv */
// gmig_checker: port-level checks of the index generator beat flow
// depends on gmig_pkg; bound to grid_mesh_index_generator_unit below

module gmig_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [gmig_pkg::IDX_W-1:0]      rsp_vertex_index,
   input  logic                            rsp_last
);
   import gmig_pkg::*;

   logic [2:0] pending_ff, pending_in;

   // beats accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && !req_stall) begin
         pending_in = pending_in + 3'd1;
      end
      if (rsp_valid && !rsp_stall) begin
         pending_in = pending_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex_index)
                                 && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // an empty result register never back-pressures the request side
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with result register empty");

   // no result beat without an outstanding request
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd0 |-> !rsp_valid)
      else $error("rsp beat without a pending request");

   // at most two beats in flight
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two beats in flight");

endmodule

bind grid_mesh_index_generator_unit gmig_checker u_gmig_checker (.*);

/* dv/grid_mesh_index_generator_unit_tb.sv */
// grid_mesh_index_generator_unit_tb: self-checking bench for the grid mesh index generator
// depends on gmig_pkg and grid_mesh_index_generator_unit; predicts edge strip and
// triangle list indices and checks every response beat against them

module grid_mesh_index_generator_unit_tb;
   import gmig_pkg::*;

   localparam int MAX_DIM          = 1024;
   localparam int CORNERS_PER_CELL = 6;
   localparam int DRAIN_CYCLES     = 4;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int QUIET_LIMIT      = 1000;

   typedef struct packed {
      logic [IDX_W-1:0] vertex_index;
      logic             last;
   } index_beat_type;

   // scoreboard: shadow traversal state and the queue of predicted indices
   class index_scoreboard;
      logic [CSR_W-1:0] rows_reg;
      logic [CSR_W-1:0] cols_reg;
      logic             active_list;
      logic             edge_phase;
      logic             row_pass_step;
      logic [2:0]       corner_slot;
      int unsigned      outer_count;
      int unsigned      inner_count;
      index_beat_type   expected_beats[$];
      int               mismatches;
      int               requests_seen;
      int               beats_checked;
      int               list_ends;

      function int unsigned clamp_dim(logic [CSR_W-1:0] value);
         if (value < 2) return 2;
         if (value > MAX_DIM) return MAX_DIM;
         return int'(value);
      endfunction

      function void restart_list();
         edge_phase    = PHASE_COLUMN;
         outer_count   = 0;
         inner_count   = 0;
         row_pass_step = 1'b0;
         corner_slot   = SLOT_BASE_A;
      endfunction

      function void reset_state();
         rows_reg    = 2;
         cols_reg    = 2;
         active_list = LIST_EDGE;
         restart_list();
         expected_beats.delete();
      endfunction

      // any register write sends the traversal back to the first index
      function void write_reg(csr_idx_type index, logic [CSR_W-1:0] value);
         if (index == CSR_GRID_ROWS) rows_reg = value;
         else cols_reg = value;
         restart_list();
      endfunction

      // next index of the selected list, advancing the shadow traversal
      function index_beat_type next_index(logic kind, logic restart);
         int unsigned    rows;
         int unsigned    cols;
         int unsigned    v;
         int unsigned    row;
         int unsigned    col;
         int unsigned    off;
         index_beat_type beat;
         rows = clamp_dim(rows_reg);
         cols = clamp_dim(cols_reg);
         beat.last = 1'b0;
         if (restart || kind != active_list) begin
            active_list = kind;
            restart_list();
         end
         if (active_list == LIST_EDGE) begin
            if (edge_phase == PHASE_COLUMN) begin
               // down even columns, up odd ones
               col = outer_count;
               row = (col % 2) ? rows - 1 - inner_count : inner_count;
               v = col * rows + row;
               inner_count++;
               if (inner_count >= rows) begin
                  inner_count = 0;
                  outer_count++;
                  if (outer_count >= cols) begin
                     edge_phase    = PHASE_ROW;
                     outer_count   = 0;
                     row_pass_step = cols[0];
                  end
               end
            end else begin
               // back across rows from where the column pass ended
               row = row_pass_step ? rows - 1 - outer_count : outer_count;
               col = (outer_count % 2) ? inner_count : cols - 1 - inner_count;
               v = col * rows + row;
               inner_count++;
               if (inner_count >= cols) begin
                  inner_count = 0;
                  outer_count++;
                  if (outer_count >= rows) begin
                     beat.last = 1'b1;
                     restart_list();
                  end
               end
            end
         end else begin
            // two triangles per cell, columns inner
            case (corner_slot)
               SLOT_NEXT_ROW:            off = 1;
               SLOT_DIAG_A, SLOT_DIAG_B: off = 1 + rows;
               SLOT_NEXT_COL:            off = rows;
               default:                  off = 0;
            endcase
            v = outer_count + inner_count * rows + off;
            corner_slot = corner_slot + 3'd1;
            if (corner_slot >= CORNERS_PER_CELL) begin
               corner_slot = SLOT_BASE_A;
               inner_count++;
               if (inner_count >= cols - 1) begin
                  inner_count = 0;
                  outer_count++;
                  if (outer_count >= rows - 1) begin
                     beat.last = 1'b1;
                     restart_list();
                  end
               end
            end
         end
         beat.vertex_index = v[IDX_W-1:0];
         return beat;
      endfunction

      function void note_request(logic kind, logic restart);
         index_beat_type beat;
         requests_seen++;
         beat = next_index(kind, restart);
         expected_beats = {expected_beats, beat};
      endfunction

      function void check_beat(logic [IDX_W-1:0] vertex_index, logic last);
         index_beat_type want;
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response beat, expected none actual index %0d last %0d",
                     $time, vertex_index, last);
            return;
         end
         want = expected_beats.pop_front();
         beats_checked++;
         if (want.last) list_ends++;
         if (vertex_index !== want.vertex_index) begin
            mismatches++;
            $display("%0t: vertex_index mismatch, expected %0d actual %0d",
                     $time, want.vertex_index, vertex_index);
         end
         if (last !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, last);
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic                 req_kind    = LIST_EDGE;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [IDX_W-1:0]     rsp_vertex_index;
   logic                 rsp_last;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_GRID_ROWS;
   logic [CSR_W-1:0]     csr_wdata   = '0;

   index_scoreboard sb;
   bit              req_gaps_on   = 1'b0;
   bit              rsp_gaps_on   = 1'b0;
   bit              long_hold_req = 1'b0;
   int              quiet_cycles  = 0;
   int              grids_programmed = 0;

   grid_mesh_index_generator_unit #(.MAX_DIM(MAX_DIM)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: csr writes, accepted beats on both channels, and the watchdog
   always @(posedge clock) begin
      if (reset) begin
         sb.reset_state();
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) sb.write_reg(csr_idx_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall) sb.note_request(req_kind, req_restart);
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_vertex_index, rsp_last);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request beat, called and returning at a falling edge
   task automatic offer_request(logic kind, logic restart);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and wait until every predicted index has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_grid(logic [CSR_W-1:0] rows, logic [CSR_W-1:0] cols);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows;
      @(negedge clock);
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cols;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      grids_programmed++;
   endtask

   // mostly long runs of one list with rare restarts and switches; the
   // noise share picks kind and restart at random
   task automatic run_lists(int count, int noise_pct);
      logic kind;
      logic restart;
      kind = 1'($urandom_range(0, 1));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            kind    = 1'($urandom_range(0, 1));
            restart = 1'($urandom_range(0, 1));
         end else begin
            restart = ($urandom_range(0, 59) == 0);
            if ($urandom_range(0, 89) == 0) kind = ~kind;
         end
         offer_request(kind, restart);
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default 2x2 grid, whole edge strip and wrap
      for (int n = 0; n < 10; n++) offer_request(LIST_EDGE, 1'b0);
      offer_request(LIST_EDGE, 1'b1);
      // switch to triangles without restart, full list of one cell
      for (int n = 0; n < 6; n++) offer_request(LIST_TRI, 1'b0);
      offer_request(LIST_TRI, 1'b0);
      offer_request(LIST_TRI, 1'b1);
      offer_request(LIST_EDGE, 1'b0);
      offer_request(LIST_EDGE, 1'b0);
      settle();
      // register write mid-list returns to the first index
      program_grid(3, 5);
      for (int n = 0; n < 4; n++) offer_request(LIST_EDGE, 1'b0);
      settle();

      // random part with idling on both sides
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      program_grid(3, 4);
      run_lists(80, 5);
      settle();
      run_lists(70, 5);
      settle();

      // values below the range clamp to 2
      program_grid(0, 1);
      run_lists(60, 40);
      settle();
      program_grid(5, 2);
      run_lists(120, 10);
      settle();

      // values above the range clamp to the maximum dimension
      program_grid(2047, 2);
      run_lists(50, 10);
      settle();
      program_grid(2, 2047);
      run_lists(50, 10);
      settle();
      program_grid(CSR_W'(MAX_DIM), CSR_W'(MAX_DIM));
      run_lists(40, 10);
      settle();

      // long receiver hold while requests keep coming
      program_grid(7, 6);
      long_hold_req = 1'b1;
      run_lists(150, 5);
      settle();

      for (int p = 0; p < 4; p++) begin
         program_grid(CSR_W'($urandom_range(2, 12)), CSR_W'($urandom_range(2, 12)));
         run_lists(100, 15);
         settle();
      end

      // closing stretch at full rate
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      program_grid(9, 7);
      run_lists(200, 5);
      settle();

      $display("covered %0d requests and %0d checked indices over %0d grid settings",
               sb.requests_seen, sb.beats_checked, grids_programmed);
      $display("edge strip and triangle list ends reached %0d times, %0d mismatches",
               sb.list_ends, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
